// ===== src/tdt_pkg.sv =====
// ----------------------------------------------------------------------------
// tdt_pkg: shared types and constants of the dedup table
// Field widths, register codes and the slot entry layout.
// ----------------------------------------------------------------------------
`default_nettype none

package tdt_pkg;

  localparam int MAC_W    = 48;
  localparam int METHOD_W = 8;
  localparam int TIME_W   = 32;
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = 3;

  localparam int SLOTS_DEF = 16;

  localparam logic [TIME_W-1:0] WINDOW_RESET = 32'd5000;

  // register index, taken from paddr[2]
  localparam logic REG_WINDOW = 1'b0;

  typedef struct packed {
    logic [MAC_W-1:0]    mac;
    logic [METHOD_W-1:0] method;
    logic [TIME_W-1:0]   time_ms;
  } slot_entry_t;

endpackage

`default_nettype wire

// ===== src/tdt_if.sv =====
// ----------------------------------------------------------------------------
// tdt_if: valid/ready channels of the dedup table
// Input channel carries the key and time, output channel the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

interface tdt_in_if;
  logic                         valid;
  logic                         ready;
  logic [tdt_pkg::MAC_W-1:0]    mac;
  logic [tdt_pkg::METHOD_W-1:0] method_id;
  logic [tdt_pkg::TIME_W-1:0]   now_ms;

  modport source (output valid, output mac, output method_id, output now_ms, input ready);
  modport sink   (input valid, input mac, input method_id, input now_ms, output ready);
endinterface

interface tdt_out_if;
  logic valid;
  logic ready;
  logic allow;

  modport source (output valid, output allow, input ready);
  modport sink   (input valid, input allow, output ready);
endinterface

`default_nettype wire

// ===== src/time_window_dedup_table_top.sv =====
// ----------------------------------------------------------------------------
// time_window_dedup_table_top: time-window duplicate filter
// Suppresses a repeated MAC/method key seen within the window; keeps the
// keys in a slot table with oldest-time eviction when full.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake              | beat payload
//  ---------+-----+------------------------+-------------------------------
//  in_ch    | in  | valid/ready            | mac, method_id, now_ms
//  out_ch   | out | valid/ready            | allow
//  apb      | in  | psel/penable, pready=1 | window_ms at address 0
//
//  An item walks each used slot through a memory read (S_READ) and a compare
//  (S_CMP), then goes to the result (S_DONE) on a hit, or first to the fill or
//  eviction (S_MISS) on a miss; a hit stops the walk early. The registered slot
//  memory read is why each slot needs both a read and a compare state.
//  Reset is synchronous and empties the table at once through the fill count.
//  in_ch is ready only while idle; a stalled out_ch holds the result, and the
//  next beat is accepted while it waits.
// ----------------------------------------------------------------------------
`default_nettype none

module time_window_dedup_table_top #(
  parameter int SLOTS = tdt_pkg::SLOTS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  tdt_in_if.sink                          in_ch,
  tdt_out_if.source                       out_ch,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [tdt_pkg::ADDR_W-1:0] paddr,
  input  wire logic [tdt_pkg::DATA_W-1:0] pwdata,
  output logic      [tdt_pkg::DATA_W-1:0] prdata,
  output logic                            pready
);
  import tdt_pkg::*;

  localparam int IDX_W = $clog2(SLOTS);

  logic [TIME_W-1:0] window;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  slot_entry_t       rd_data;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  slot_entry_t       wr_data;

  tdt_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .window  (window)
  );

  tdt_table #(.SLOTS(SLOTS)) u_table (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  tdt_scan #(.SLOTS(SLOTS)) u_scan (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .window  (window),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

endmodule

`default_nettype wire

// ===== src/tdt_cfg.sv =====
// ----------------------------------------------------------------------------
// tdt_cfg: APB register block
// Holds the suppression window register.
// ----------------------------------------------------------------------------
`default_nettype none

module tdt_cfg (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [tdt_pkg::ADDR_W-1:0] paddr,
  input  wire logic [tdt_pkg::DATA_W-1:0] pwdata,
  output logic      [tdt_pkg::DATA_W-1:0] prdata,
  output logic                            pready,
  output logic      [tdt_pkg::TIME_W-1:0] window
);
  import tdt_pkg::*;

  logic wr_window;

  assign pready    = 1'b1;
  assign wr_window = psel && penable && pwrite && (paddr[2] == REG_WINDOW);

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= WINDOW_RESET;
    end else if (wr_window) begin
      window <= pwdata;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_WINDOW) begin
      prdata = window;
    end
  end

endmodule

`default_nettype wire

// ===== src/tdt_table.sv =====
// ----------------------------------------------------------------------------
// tdt_table: slot memory
// One write port and one registered read port over the slot entries.
// ----------------------------------------------------------------------------
`default_nettype none

module tdt_table #(
  parameter int SLOTS = tdt_pkg::SLOTS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rd_en,
  input  wire logic [$clog2(SLOTS)-1:0]    rd_addr,
  output tdt_pkg::slot_entry_t             rd_data,
  input  wire logic                        wr_en,
  input  wire logic [$clog2(SLOTS)-1:0]    wr_addr,
  input  tdt_pkg::slot_entry_t             wr_data
);
  import tdt_pkg::*;

  slot_entry_t mem [SLOTS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== src/tdt_scan.sv =====
// ----------------------------------------------------------------------------
// tdt_scan: slot walk sequencer
// Walks the used slots one at a time through a shared key/age/time compare,
// then refreshes, fills or evicts and posts the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module tdt_scan #(
  parameter int SLOTS = tdt_pkg::SLOTS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  tdt_in_if.sink                          in_ch,
  tdt_out_if.source                       out_ch,
  input  wire logic [tdt_pkg::TIME_W-1:0] window,
  output logic                            rd_en,
  output logic      [$clog2(SLOTS)-1:0]   rd_addr,
  input  tdt_pkg::slot_entry_t            rd_data,
  output logic                            wr_en,
  output logic      [$clog2(SLOTS)-1:0]   wr_addr,
  output tdt_pkg::slot_entry_t            wr_data
);
  import tdt_pkg::*;

  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_CMP  = 3'd2;
  localparam logic [2:0] S_MISS = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]          state;
  logic [CNT_W-1:0]    pos;
  logic [CNT_W-1:0]    fill;
  logic [MAC_W-1:0]    key_mac;
  logic [METHOD_W-1:0] key_method;
  logic [TIME_W-1:0]   key_now;
  logic [TIME_W-1:0]   min_time;
  logic [IDX_W-1:0]    min_idx;
  logic                res_allow;
  logic                out_valid;
  logic                out_allow;

  logic              hit;
  logic [TIME_W-1:0] age;
  logic              suppress;
  logic              older;
  logic              last;
  logic              full;

  // shared compare unit, fed by the slot just read
  assign hit      = (rd_data.mac == key_mac) && (rd_data.method == key_method);
  assign age      = key_now - rd_data.time_ms;
  assign suppress = age < window;
  assign older    = (pos == '0) || (rd_data.time_ms < min_time);
  assign last     = (pos + CNT_W'(1)) == fill;
  assign full     = fill == CNT_W'(SLOTS);

  assign rd_en   = state == S_READ;
  assign rd_addr = pos[IDX_W-1:0];
  assign wr_en   = ((state == S_CMP) && hit && !suppress) || (state == S_MISS);
  assign wr_data = '{mac: key_mac, method: key_method, time_ms: key_now};

  always_comb begin
    wr_addr = pos[IDX_W-1:0];
    if (state == S_MISS) begin
      // take the next free slot, else the oldest
      wr_addr = full ? min_idx : fill[IDX_W-1:0];
    end
  end

  assign in_ch.ready  = state == S_IDLE;
  assign out_ch.valid = out_valid;
  assign out_ch.allow = out_allow;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pos       <= '0;
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      // S_DONE reloads the output register itself
      if (out_valid && out_ch.ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            key_mac    <= in_ch.mac;
            key_method <= in_ch.method_id;
            key_now    <= in_ch.now_ms;
            pos        <= '0;
            state      <= (fill == '0) ? S_MISS : S_READ;
          end
        end
        S_READ: begin
          state <= S_CMP;
        end
        S_CMP: begin
          if (hit) begin
            res_allow <= !suppress;
            state     <= S_DONE;
          end else begin
            if (older) begin
              min_time <= rd_data.time_ms;
              min_idx  <= pos[IDX_W-1:0];
            end
            pos   <= pos + CNT_W'(1);
            state <= last ? S_MISS : S_READ;
          end
        end
        S_MISS: begin
          if (!full) begin
            fill <= fill + CNT_W'(1);
          end
          res_allow <= 1'b1;
          state     <= S_DONE;
        end
        S_DONE: begin
          // hold until the output register is free
          if (!out_valid || out_ch.ready) begin
            out_valid <= 1'b1;
            out_allow <= res_allow;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
